// ===== sv/aes_pkg.sv =====
// ----------------------------------------------------------------------------
// AES package
// S-box, round constants and round helper functions for the AES-128 pipeline.
// ----------------------------------------------------------------------------
package aes_pkg;

	localparam int NumRounds = 10;
	localparam int RndW      = 4;
	localparam logic [7:0] GfReduce = 8'h1B;

	typedef logic [127:0] block_t;
	typedef logic [RndW-1:0] rnd_t;

	typedef struct packed {
		block_t pt;
		block_t key;
	} aes_in_t;

	typedef struct packed {
		block_t ct;
	} aes_out_t;

	function automatic logic [7:0] sbox(input logic [7:0] x);
		logic [7:0] tbl [256];
		tbl = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		return tbl[x];
	endfunction

	function automatic logic [7:0] rcon(input rnd_t r);
		logic [7:0] v;
		unique case (r)
			4'd0: v = 8'h01;
			4'd1: v = 8'h02;
			4'd2: v = 8'h04;
			4'd3: v = 8'h08;
			4'd4: v = 8'h10;
			4'd5: v = 8'h20;
			4'd6: v = 8'h40;
			4'd7: v = 8'h80;
			4'd8: v = 8'h1b;
			4'd9: v = 8'h36;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

	// byte k of the state sits at bits 127-8k
	function automatic logic [7:0] get_byte(input block_t b, input int k);
		return b[127-8*k -: 8];
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? GfReduce : 8'h00);
	endfunction

	function automatic block_t next_key(input block_t rk, input rnd_t r);
		logic [31:0] t;
		block_t n;
		t = {sbox(get_byte(rk, 13)) ^ rcon(r), sbox(get_byte(rk, 14)),
			sbox(get_byte(rk, 15)), sbox(get_byte(rk, 12))};
		n[127:96] = rk[127:96] ^ t;
		n[95:64]  = rk[95:64] ^ n[127:96];
		n[63:32]  = rk[63:32] ^ n[95:64];
		n[31:0]   = rk[31:0] ^ n[63:32];
		return n;
	endfunction

	function automatic block_t sub_shift(input block_t s);
		block_t t;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[127-8*(r+4*c) -: 8] = sbox(get_byte(s, r + 4*((c + r) % 4)));
			end
		end
		return t;
	endfunction

	function automatic block_t mix_columns(input block_t s);
		block_t t;
		logic [7:0] a0, a1, a2, a3, d0, d1, d2, d3;
		for (int c = 0; c < 4; c++) begin
			a0 = get_byte(s, 4*c);
			a1 = get_byte(s, 4*c+1);
			a2 = get_byte(s, 4*c+2);
			a3 = get_byte(s, 4*c+3);
			d0 = xtime(a0);
			d1 = xtime(a1);
			d2 = xtime(a2);
			d3 = xtime(a3);
			t[127-32*c -: 32] = {d0 ^ d1 ^ a1 ^ a2 ^ a3, a0 ^ d1 ^ d2 ^ a2 ^ a3,
				a0 ^ a1 ^ d2 ^ d3 ^ a3, d0 ^ a0 ^ a1 ^ a2 ^ d3};
		end
		return t;
	endfunction

endpackage

// ===== sv/aes_if.sv =====
// ----------------------------------------------------------------------------
// AES stream channel
// Valid/ready channels carrying the plaintext/key payload and the ciphertext.
// ----------------------------------------------------------------------------
interface aes_in_if;
	logic             valid;
	logic             ready;
	aes_pkg::aes_in_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface aes_out_if;
	logic              valid;
	logic              ready;
	aes_pkg::aes_out_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/aes_round.sv =====
// ----------------------------------------------------------------------------
// AES round stage
// One registered round: SubBytes, ShiftRows, optional MixColumns, key add.
// ----------------------------------------------------------------------------
module aes_round (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  aes_pkg::rnd_t   rnd,
	input  logic            valid_in,
	input  aes_pkg::block_t state_in,
	input  aes_pkg::block_t key_in,
	output logic            valid_s1,
	output aes_pkg::block_t state_s1,
	output aes_pkg::block_t key_s1
);
	aes_pkg::block_t nk;
	aes_pkg::block_t ss;
	aes_pkg::block_t mc;

	always_comb begin
		nk = aes_pkg::next_key(key_in, rnd);
		ss = aes_pkg::sub_shift(state_in);
		mc = (rnd == aes_pkg::rnd_t'(aes_pkg::NumRounds - 1)) ? ss : aes_pkg::mix_columns(ss);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			state_s1 <= mc ^ nk;
			key_s1   <= nk;
		end
	end
endmodule

// ===== sv/aes128_encrypt_block.sv =====
// ----------------------------------------------------------------------------
// AES-128 encryption pipeline
// From input transfer to result valid, the data passes one key-add stage,
// then one register stage per round. Throughput: one block per cycle while the
// output is not stalled, set by the ten unrolled round stages. A stall holds the whole pipeline.
// Reset clears all valid bits; no other state.
// ----------------------------------------------------------------------------
module aes128_encrypt_block (
	input logic       clk,
	input logic       arst_n,
	aes_in_if.sink    in_ch,
	aes_out_if.source out_ch
);
	localparam int NumStg = aes_pkg::NumRounds + 1;

	logic            vld [NumStg];
	aes_pkg::block_t st  [NumStg];
	aes_pkg::block_t ky  [NumStg];
	logic            adv;

	// Advance everything when the last stage is empty or is being taken.
	assign adv = !vld[NumStg-1] || out_ch.ready;
	assign in_ch.ready = adv;

	// Initial round-key add.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld[0] <= 1'b0;
		end else if (adv) begin
			vld[0] <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st[0] <= in_ch.data.pt ^ in_ch.data.key;
			ky[0] <= in_ch.data.key;
		end
	end

	for (genvar g = 0; g < aes_pkg::NumRounds; g++) begin : g_rnd
		aes_round u_round (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.rnd      (aes_pkg::rnd_t'(g)),
			.valid_in (vld[g]),
			.state_in (st[g]),
			.key_in   (ky[g]),
			.valid_s1 (vld[g+1]),
			.state_s1 (st[g+1]),
			.key_s1   (ky[g+1])
		);
	end

	assign out_ch.valid   = vld[NumStg-1];
	assign out_ch.data.ct = st[NumStg-1];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data.ct))
		else $error("result changed while stalled");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_ch.valid |-> in_ch.ready)
		else $error("input blocked with empty output");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |=> vld[0] == $past(in_ch.valid))
		else $error("entry valid lost");
endmodule
